// File: hdl/igfr_pkg.sv
// Package for the idle-gap frame receiver.
// Holds the store size, derived widths, command and state codes and the
// stage word passed from the control block to the result stage. No dependencies.
package igfr_pkg;

    // Frame store depth and widths that follow from it
    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int CMP_W        = (CNT_W > 8) ? CNT_W : 8;

    // Fixed field widths
    localparam int TIMEOUT_W = 16;
    localparam int DATA_W    = 8;
    localparam int INDEX_W   = 8;
    localparam int OUT_CNT_W = 9;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_AT_RESET = 16'd50;
    localparam logic [TIMEOUT_W-1:0] TICKS_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_BYTE    = 2'd1,
        CMD_READ    = 2'd2,
        CMD_RELEASE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE      = 2'd0,
        ST_RECEIVING = 2'd1,
        ST_ENDED     = 2'd2
    } rx_state_t;

    // Status after one word has been applied
    typedef struct packed {
        rx_state_t              rx_state;
        logic [OUT_CNT_W-1:0]   byte_count;
        logic                   error_seen;
        logic                   frame_done;
        logic                   port_idle;
        logic                   read_hit;
    } stage_t;

endpackage

// File: hdl/igfr_intf.sv
// Channel interfaces for the idle-gap frame receiver: command words in,
// status words out, each with valid/ready. Depends on igfr_pkg for widths.
interface igfr_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    command;
    logic [igfr_pkg::DATA_W-1:0]   rx_byte;
    logic                          line_error;
    logic [igfr_pkg::INDEX_W-1:0]  read_index;

    modport source (output valid, command, rx_byte, line_error, read_index, input ready);
    modport sink   (input valid, command, rx_byte, line_error, read_index, output ready);
endinterface

interface igfr_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      rx_state;
    logic [igfr_pkg::OUT_CNT_W-1:0]  byte_count;
    logic                            error_seen;
    logic [igfr_pkg::DATA_W-1:0]     read_data;
    logic                            frame_done;
    logic                            port_idle;

    modport source (output valid, rx_state, byte_count, error_seen, read_data, frame_done,
                    port_idle, input ready);
    modport sink   (input valid, rx_state, byte_count, error_seen, read_data, frame_done,
                    port_idle, output ready);
endinterface

// File: hdl/idle_gap_frame_receiver_unit.sv
// Top level of the idle-gap frame receiver.
// Depends on igfr_pkg, igfr_intf, igfr_ram, igfr_ctrl and igfr_out_stage.

// Collects received bytes into a frame store and ends the frame after
// idle_timeout ticks of silence. Takes one command word per clock cycle
// unless the sink stalls; each word yields exactly one status word, staged
// while the frame store's registered read port fetches read data, then held
// in the output register. The output register and a staging register let a
// new word enter while a finished status word waits for the sink. The store
// needs no clearing after reset: only positions below the current count
// are read back. Write idle_timeout only while no word is in flight.
module idle_gap_frame_receiver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [igfr_pkg::TIMEOUT_W-1:0]  cfg_wr_data,
    igfr_req_if.sink                        req,
    igfr_rsp_if.source                      rsp
);

    logic                              accept;
    logic                              in_ready;
    igfr_pkg::stage_t                  status;
    igfr_pkg::stage_t                  out_status;
    logic                              ram_we;
    logic [igfr_pkg::ADDR_W-1:0]       ram_waddr;
    logic                              ram_re;
    logic [igfr_pkg::ADDR_W-1:0]       ram_raddr;
    logic [igfr_pkg::DATA_W-1:0]       ram_rdata;
    logic [igfr_pkg::DATA_W-1:0]       out_read_data;
    logic                              out_valid;

    assign accept    = req.valid && in_ready;
    assign req.ready = in_ready;

    igfr_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .command     (req.command),
        .rx_byte     (req.rx_byte),
        .line_error  (req.line_error),
        .read_index  (req.read_index),
        .status      (status),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr)
    );

    igfr_ram #(
        .WIDTH (igfr_pkg::DATA_W),
        .DEPTH (igfr_pkg::BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.rx_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    igfr_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .status        (status),
        .ram_rdata     (ram_rdata),
        .out_ready     (rsp.ready),
        .in_ready      (in_ready),
        .out_valid     (out_valid),
        .out_status    (out_status),
        .out_read_data (out_read_data)
    );

    // Drive the result channel
    assign rsp.valid      = out_valid;
    assign rsp.rx_state   = out_status.rx_state;
    assign rsp.byte_count = out_status.byte_count;
    assign rsp.error_seen = out_status.error_seen;
    assign rsp.read_data  = out_read_data;
    assign rsp.frame_done = out_status.frame_done;
    assign rsp.port_idle  = out_status.port_idle;

endmodule

// File: hdl/igfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module igfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/igfr_ctrl.sv
// Receive control for the idle-gap frame receiver: state, silence timer,
// byte count, error flag and frame store addressing. Depends on igfr_pkg.
module igfr_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [igfr_pkg::TIMEOUT_W-1:0]  cfg_wr_data,
    input  logic                            accept,
    input  logic [1:0]                      command,
    input  logic [igfr_pkg::DATA_W-1:0]     rx_byte,
    input  logic                            line_error,
    input  logic [igfr_pkg::INDEX_W-1:0]    read_index,
    output igfr_pkg::stage_t                status,
    output logic                            ram_we,
    output logic [igfr_pkg::ADDR_W-1:0]     ram_waddr,
    output logic                            ram_re,
    output logic [igfr_pkg::ADDR_W-1:0]     ram_raddr
);

    logic [igfr_pkg::TIMEOUT_W-1:0] timeout_reg;
    igfr_pkg::rx_state_t            state_reg, state_next;
    logic                           running_reg, running_next;
    logic [igfr_pkg::TIMEOUT_W-1:0] ticks_reg, ticks_next, ticks_inc;
    logic [igfr_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           err_reg, err_next;
    logic                           done;
    logic                           hit;
    logic                           room;
    logic [igfr_pkg::CMP_W-1:0]     idx_wide;
    logic [igfr_pkg::CMP_W-1:0]     cnt_wide;

    // Saturating silence count and store bounds
    assign ticks_inc = (ticks_reg < igfr_pkg::TICKS_MAX) ? ticks_reg + 16'd1 : ticks_reg;
    assign room      = (count_reg < igfr_pkg::CNT_W'(igfr_pkg::BUFFER_DEPTH));
    assign idx_wide  = igfr_pkg::CMP_W'(read_index);
    assign cnt_wide  = igfr_pkg::CMP_W'(count_reg);

    // Apply one command word
    always_comb
    begin
        state_next   = state_reg;
        running_next = running_reg;
        ticks_next   = ticks_reg;
        count_next   = count_reg;
        err_next     = err_reg;
        done         = 1'b0;
        hit          = 1'b0;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (igfr_pkg::cmd_t'(command))
            igfr_pkg::CMD_TICK:
            begin
                if (running_reg)
                begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_reg)
                    begin
                        running_next = 1'b0;
                        if (state_reg == igfr_pkg::ST_RECEIVING)
                        begin
                            state_next = igfr_pkg::ST_ENDED;
                            done       = 1'b1;
                        end
                    end
                end
            end
            igfr_pkg::CMD_BYTE:
            begin
                ticks_next   = '0;
                running_next = 1'b1;
                if (state_reg != igfr_pkg::ST_ENDED)
                begin
                    state_next = igfr_pkg::ST_RECEIVING;
                    if (room)
                    begin
                        err_next   = err_reg | line_error;
                        count_next = count_reg + 1'b1;
                        ram_we     = accept;
                    end
                end
            end
            igfr_pkg::CMD_READ:
            begin
                hit    = (idx_wide < cnt_wide) &&
                         (idx_wide < igfr_pkg::CMP_W'(igfr_pkg::BUFFER_DEPTH));
                ram_re = accept;
            end
            igfr_pkg::CMD_RELEASE:
            begin
                state_next   = igfr_pkg::ST_IDLE;
                running_next = 1'b0;
                ticks_next   = '0;
                count_next   = '0;
                err_next     = 1'b0;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    assign ram_waddr = igfr_pkg::ADDR_W'(count_reg);
    assign ram_raddr = igfr_pkg::ADDR_W'(read_index);

    // Status as it stands after the word
    always_comb
    begin
        status.rx_state   = state_next;
        status.byte_count = igfr_pkg::OUT_CNT_W'(count_next);
        status.error_seen = err_next;
        status.frame_done = done;
        status.port_idle  = (state_next == igfr_pkg::ST_IDLE);
        status.read_hit   = hit;
    end

    // Timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= igfr_pkg::TIMEOUT_AT_RESET;
        end
        else if (cfg_wr_en)
        begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // Advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= igfr_pkg::ST_IDLE;
            running_reg <= 1'b0;
            ticks_reg   <= '0;
            count_reg   <= '0;
            err_reg     <= 1'b0;
        end
        else if (accept)
        begin
            state_reg   <= state_next;
            running_reg <= running_next;
            ticks_reg   <= ticks_next;
            count_reg   <= count_next;
            err_reg     <= err_next;
        end
    end

endmodule

// File: hdl/igfr_out_stage.sv
// Result staging for the idle-gap frame receiver: a stage that waits for
// frame store read data, then the output register. Depends on igfr_pkg.
module igfr_out_stage (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  igfr_pkg::stage_t                status,
    input  logic [igfr_pkg::DATA_W-1:0]     ram_rdata,
    input  logic                            out_ready,
    output logic                            in_ready,
    output logic                            out_valid,
    output igfr_pkg::stage_t                out_status,
    output logic [igfr_pkg::DATA_W-1:0]     out_read_data
);

    logic                        s1_valid_reg, s1_valid_next;
    igfr_pkg::stage_t            s1_reg;
    logic                        out_valid_reg, out_valid_next;
    igfr_pkg::stage_t            out_reg;
    logic [igfr_pkg::DATA_W-1:0] rdata_reg;
    logic                        s1_adv;

    // Move the staged word on when the output register is free or draining
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: capture status, then merge in read data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= status;
        end
        if (s1_adv)
        begin
            out_reg   <= s1_reg;
            rdata_reg <= s1_reg.read_hit ? ram_rdata : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_status    = out_reg;
    assign out_read_data = rdata_reg;

endmodule

// File: bench/tb_top.sv
// Self-checking bench for idle_gap_frame_receiver_unit: predicts each status
// word from a local copy of the receiver state and compares it field by field.
// Depends on igfr_pkg, igfr_req_if, igfr_rsp_if and the unit itself.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int PRINT_CAP   = 200;

    typedef struct {
        igfr_pkg::cmd_t  command;
        logic [7:0]      rx_byte;
        logic            line_error;
        logic [7:0]      read_index;
    } rx_word_t;

    typedef struct {
        igfr_pkg::rx_state_t  rx_state;
        logic [8:0]           byte_count;
        logic                 error_seen;
        logic [7:0]           read_data;
        logic                 frame_done;
        logic                 port_idle;
    } status_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [igfr_pkg::TIMEOUT_W-1:0] cfg_wr_data;

    igfr_req_if req_ch ();
    igfr_rsp_if rsp_ch ();

    idle_gap_frame_receiver_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    // Receiver state as the bench expects it
    logic [15:0]          timeout_reg;
    igfr_pkg::rx_state_t  rx_mode;
    logic                 timer_on;
    logic [15:0]          silence;
    int                   stored;
    logic                 err_sticky;
    logic [7:0]           frame_bytes [igfr_pkg::BUFFER_DEPTH];

    rx_word_t word_queue [$];
    status_t  status_due [$];
    rx_word_t cur_word;
    status_t  got_status;
    status_t  want_status;

    int words_open;
    int words_pushed;
    int error_count;
    int quiet_cycles;
    bit word_taken;

    int burst_left;
    int gap_left;
    int ready_mode;
    int ready_left;
    int stall_phase;

    // Clock: 10 ns period
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Work out the status word that one accepted word leaves behind
    function automatic status_t predict_status(input rx_word_t w);
        status_t s;
        s.read_data  = '0;
        s.frame_done = 1'b0;
        case (w.command)
            igfr_pkg::CMD_TICK:
            begin
                if (timer_on)
                begin
                    if (silence != 16'hFFFF)
                        silence = silence + 16'd1;
                    if (silence >= timeout_reg)
                    begin
                        timer_on = 1'b0;
                        if (rx_mode == igfr_pkg::ST_RECEIVING)
                        begin
                            rx_mode      = igfr_pkg::ST_ENDED;
                            s.frame_done = 1'b1;
                        end
                    end
                end
            end
            igfr_pkg::CMD_BYTE:
            begin
                silence  = '0;
                timer_on = 1'b1;
                if (rx_mode != igfr_pkg::ST_ENDED)
                begin
                    rx_mode = igfr_pkg::ST_RECEIVING;
                    if (stored < igfr_pkg::BUFFER_DEPTH)
                    begin
                        if (w.line_error)
                            err_sticky = 1'b1;
                        frame_bytes[stored[igfr_pkg::ADDR_W-1:0]] = w.rx_byte;
                        stored++;
                    end
                end
            end
            igfr_pkg::CMD_READ:
            begin
                if (int'(w.read_index) < stored)
                    s.read_data = frame_bytes[w.read_index];
            end
            default:
            begin
                rx_mode    = igfr_pkg::ST_IDLE;
                timer_on   = 1'b0;
                silence    = '0;
                stored     = 0;
                err_sticky = 1'b0;
            end
        endcase
        s.rx_state   = rx_mode;
        s.byte_count = stored[8:0];
        s.error_seen = err_sticky;
        s.port_idle  = (rx_mode == igfr_pkg::ST_IDLE);
        return s;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("%0t mismatch on %s: got %0d, want %0d", $time, field, got, want);
    endtask

    // Sender: bursts of random length with random gaps, hold a word until taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (req_ch.valid && !word_taken)
        begin
            // hold the current word
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            req_ch.valid <= 1'b0;
        end
        else if (word_queue.size() > 0)
        begin
            cur_word = word_queue.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.command    <= cur_word.command;
            req_ch.rx_byte    <= cur_word.rx_byte;
            req_ch.line_error <= cur_word.line_error;
            req_ch.read_index <= cur_word.read_index;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        else
        begin
            req_ch.valid <= 1'b0;
        end
        word_taken = 1'b0;
    end

    // Receiver: stall on a pattern that changes mode every so often
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end
        ready_left--;
        stall_phase++;
        case (ready_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= ((stall_phase % 5) < 3);
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Monitor: check finished status words, predict for accepted command words
    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (status_due.size() == 0)
            begin
                report_mismatch("unexpected word", 1, 0);
            end
            else
            begin
                want_status = status_due.pop_front();
                if (rsp_ch.rx_state !== want_status.rx_state)
                    report_mismatch("rx_state", int'(rsp_ch.rx_state),
                                    int'(want_status.rx_state));
                if (rsp_ch.byte_count !== want_status.byte_count)
                    report_mismatch("byte_count", int'(rsp_ch.byte_count),
                                    int'(want_status.byte_count));
                if (rsp_ch.error_seen !== want_status.error_seen)
                    report_mismatch("error_seen", int'(rsp_ch.error_seen),
                                    int'(want_status.error_seen));
                if (rsp_ch.read_data !== want_status.read_data)
                    report_mismatch("read_data", int'(rsp_ch.read_data),
                                    int'(want_status.read_data));
                if (rsp_ch.frame_done !== want_status.frame_done)
                    report_mismatch("frame_done", int'(rsp_ch.frame_done),
                                    int'(want_status.frame_done));
                if (rsp_ch.port_idle !== want_status.port_idle)
                    report_mismatch("port_idle", int'(rsp_ch.port_idle),
                                    int'(want_status.port_idle));
            end
        end
        if (req_ch.valid && req_ch.ready)
        begin
            status_due.push_back(predict_status(cur_word));
            words_open--;
            word_taken = 1'b1;
        end
        // advance the stall count only while something is outstanding
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (words_open == 0 && status_due.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog: give up when nothing moves for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("tb_top: errors");
        $finish;
    end

    task automatic push_word(input igfr_pkg::cmd_t c, input logic [7:0] d, input logic e,
                             input logic [7:0] ix);
        rx_word_t w;
        w.command    = c;
        w.rx_byte    = d;
        w.line_error = e;
        w.read_index = ix;
        word_queue.push_back(w);
        words_open++;
        words_pushed++;
    endtask

    task automatic push_tick();
        push_word(igfr_pkg::CMD_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(0, 255)));
    endtask

    task automatic push_byte(input logic [7:0] d, input logic e);
        push_word(igfr_pkg::CMD_BYTE, d, e, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_read(input logic [7:0] ix);
        push_word(igfr_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  ix);
    endtask

    task automatic push_release();
        push_word(igfr_pkg::CMD_RELEASE, 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    // Wait for every outstanding word and status, then let the pipeline empty
    task automatic settle();
        while (words_open != 0 || status_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_timeout(input logic [15:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        timeout_reg = v;
    endtask

    // Ticks of silence between bytes: mostly short of the timeout; with a
    // small timeout, now and then past it
    function automatic int gap_ticks();
        int top;
        if ($urandom_range(0, 19) == 0)
            return (timeout_reg > 8) ? $urandom_range(0, 8) : timeout_reg + $urandom_range(0, 3);
        if (timeout_reg == 0)
            return 0;
        top = (timeout_reg - 1 > 6) ? 6 : timeout_reg - 1;
        return $urandom_range(0, top);
    endfunction

    // One well-formed frame with random content, with the odd broken step
    task automatic queue_frame(input int n);
        int k;
        int top;
        for (int i = 0; i < n; i++)
        begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            if ($urandom_range(0, 2) == 0)
            begin
                k = gap_ticks();
                repeat (k) push_tick();
            end
        end
        if ($urandom_range(0, 7) != 0)
        begin
            k = (timeout_reg > 24) ? $urandom_range(0, 24) : timeout_reg;
            k = k + $urandom_range(0, 2);
            repeat (k) push_tick();
        end
        top = (n > igfr_pkg::BUFFER_DEPTH) ? igfr_pkg::BUFFER_DEPTH - 1 : n - 1;
        repeat ($urandom_range(0, 4))
        begin
            if ($urandom_range(0, 4) == 0)
                push_read(8'($urandom_range(0, 255)));
            else
                push_read(8'($urandom_range(0, top)));
        end
        if ($urandom_range(0, 3) == 0)
            push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) != 0)
            push_release();
    endtask

    task automatic queue_noise(input int n);
        repeat (n)
            push_word(igfr_pkg::cmd_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endtask

    task automatic queue_random_phase(input int target, input bit fill_store);
        int start;
        int r;
        start = words_pushed;
        if (fill_store)
            queue_frame(igfr_pkg::BUFFER_DEPTH + 4);
        while (words_pushed - start < target)
        begin
            r = $urandom_range(0, 9);
            if (r < 7)
                queue_frame($urandom_range(1, 16));
            else if (r == 7)
                queue_frame($urandom_range(17, 60));
            else
                queue_noise($urandom_range(1, 8));
        end
    endtask

    logic [15:0] phase_timeout [8];

    initial
    begin
        // drive every input to a known value before reset
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_ch.valid      = 1'b0;
        req_ch.command    = igfr_pkg::CMD_TICK;
        req_ch.rx_byte    = '0;
        req_ch.line_error = 1'b0;
        req_ch.read_index = '0;
        rsp_ch.ready      = 1'b0;
        words_open   = 0;
        words_pushed = 0;
        error_count  = 0;
        word_taken   = 1'b0;
        burst_left   = 0;
        gap_left     = 0;
        ready_mode   = 0;
        ready_left   = 0;
        stall_phase  = 0;
        timeout_reg  = igfr_pkg::TIMEOUT_AT_RESET;
        rx_mode      = igfr_pkg::ST_IDLE;
        timer_on     = 1'b0;
        silence      = '0;
        stored       = 0;
        err_sticky   = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: stopped timer, empty reads, extreme values, frame end,
        // byte after end, timeout outside a frame, release in the idle and ended states
        set_timeout(16'd3);
        push_tick();
        push_read(8'd0);
        push_release();
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_read(8'd1);
        push_read(8'd255);
        repeat (3) push_tick();
        push_tick();
        push_byte(8'hA5, 1'b0);
        repeat (3) push_tick();
        push_release();
        push_byte(8'h5A, 1'b0);
        push_tick();
        settle();

        // lower the timeout to the running count: next tick ends the frame
        set_timeout(16'd1);
        push_tick();
        push_read(8'd0);
        push_release();
        settle();

        // zero timeout: the first tick after a byte ends the frame
        set_timeout(16'd0);
        push_byte(8'h3C, 1'b0);
        push_tick();
        push_release();
        settle();

        // random phases, draining completely between them
        phase_timeout[0] = 16'd2;
        phase_timeout[1] = 16'd0;
        phase_timeout[2] = 16'hFFFF;
        phase_timeout[3] = 16'd5;
        phase_timeout[4] = 16'd1;
        phase_timeout[5] = 16'($urandom_range(1, 12));
        phase_timeout[6] = 16'd4;
        phase_timeout[7] = igfr_pkg::TIMEOUT_AT_RESET;
        for (int p = 0; p < 8; p++)
        begin
            set_timeout(phase_timeout[p]);
            queue_random_phase(155, p == 3);
            settle();
        end

        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
